// ===== hdl/tdma_pkg.sv =====
// Shared types and constants of the time-of-day moving average core.
`default_nettype none
package tdma_pkg;

    localparam int HOURS_W   = 5;
    localparam int MINUTES_W = 6;
    localparam int SECONDS_W = 6;
    localparam int STAMP_W   = 17;
    localparam int WIN_W     = 7;
    // A window holds at most 127 stamps of at most 115443 each.
    localparam int SUM_W     = STAMP_W + WIN_W;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 24;

    localparam logic [STAMP_W-1:0] HOUR_SECS = 17'd3600;
    localparam logic [STAMP_W-1:0] MIN_SECS  = 17'd60;

    // Sequencer states.
    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_IDLE = 2'd0;
    localparam logic [ST_W-1:0] ST_UPD  = 2'd1;
    localparam logic [ST_W-1:0] ST_DIV  = 2'd2;
    localparam logic [ST_W-1:0] ST_OUT  = 2'd3;

    typedef logic [STAMP_W-1:0] stamp_t;
    typedef logic [SUM_W-1:0]   sum_t;
    typedef logic [WIN_W-1:0]   win_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage
`default_nettype wire

// ===== hdl/tdma_ring.sv =====
// Sample ring memory: one write port, one read port with registered data.
`default_nettype none
module tdma_ring #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic                           aclk,
    input  wire logic                           rd_en,
    input  wire logic [ADDR_W-1:0]              rd_addr,
    output logic      [tdma_pkg::STAMP_W-1:0]   rd_data,
    input  wire logic                           wr_en,
    input  wire logic [ADDR_W-1:0]              wr_addr,
    input  wire logic [tdma_pkg::STAMP_W-1:0]   wr_data
);
    import tdma_pkg::*;

    stamp_t mem [0:DEPTH-1];
    stamp_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== hdl/tdma_div.sv =====
// Restoring divider: one quotient bit per cycle, window sum by window length.
`default_nettype none
module tdma_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [tdma_pkg::SUM_W-1:0]   dividend,
    input  wire logic [tdma_pkg::WIN_W-1:0]   divisor,
    output tdma_pkg::div_status_t             status,
    output logic      [tdma_pkg::STAMP_W-1:0] quotient
);
    import tdma_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    sum_t             dvd_reg, dvd_next;
    win_t             rem_reg, rem_next;
    win_t             dsr_reg, dsr_next;
    logic [WIN_W:0]   rem_sh;
    logic             ge;

    always_comb begin
        rem_sh    = {rem_reg, dvd_reg[SUM_W-1]};
        ge        = (rem_sh >= {1'b0, dsr_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(SUM_W);
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            // shift in the next dividend bit, subtract where it fits
            rem_next = ge ? WIN_W'(rem_sh - {1'b0, dsr_reg}) : WIN_W'(rem_sh);
            dvd_next = {dvd_reg[SUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    // the average never exceeds the largest stamp
    assign quotient    = dvd_reg[STAMP_W-1:0];

endmodule
`default_nettype wire

// ===== hdl/time_of_day_moving_average_core.sv =====
// Top level of the time-of-day boxcar moving average core.
//
//  channel   | direction | handshake          | content
//  ----------+-----------+--------------------+------------------------------------
//  s_        | in        | s_tvalid/s_tready  | time stamp, tuser = first of sequence
//  m_        | out       | m_tvalid/m_tready  | floor average, seconds since midnight
//  cfg_      | in        | cfg_wr_en          | window length, no read-back
//
// An item that yields a result passes from acceptance to the output register
// through the ring read of its slot, the update of sum and ring, and the
// bit-serial divider, which works through the window sum bit by bit.
// An item that yields no result frees the input after the update of sum and ring.
// Reset (aresetn low, synchronous) clears sum, fill count, pointer and the
// window length to 1. The ring needs no clearing: a slot's data is used only once
// written. A stall on m_ holds the finished average in the divider and stops
// further input until the output register frees up.
`default_nettype none
module time_of_day_moving_average_core #(
    parameter int MAX_WINDOW = 64
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration
    input  wire logic                             cfg_wr_en,
    input  wire logic [tdma_pkg::WIN_W-1:0]       cfg_wr_data,   // window_len
    // input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [tdma_pkg::S_DATA_W-1:0]    s_tdata,   // hours, minutes, seconds
    input  wire logic                             s_tuser,   // first_of_sequence
    // result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [tdma_pkg::M_DATA_W-1:0]    m_tdata    // average_seconds
);
    import tdma_pkg::*;

    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CMP_W = (PTR_W > WIN_W) ? PTR_W : WIN_W;
    localparam int W_TOP = (MAX_WINDOW > 127) ? 127 : MAX_WINDOW;

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    logic [ST_W-1:0]  state_reg, state_next;
    win_t             window_len_reg, window_len_next;
    sum_t             sum_reg, sum_next;
    win_t             fill_reg, fill_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    stamp_t           v_reg, v_next;
    logic [PTR_W-1:0] slot_reg, slot_next;
    logic             evict_reg, evict_next;
    logic             emit_reg, emit_next;
    logic             m_tvalid_reg, m_tvalid_next;
    stamp_t           m_data_reg, m_data_next;

    // ---------------------------------------------------------------
    // Input decode and combinational helpers
    // ---------------------------------------------------------------
    logic [HOURS_W-1:0]   in_hours;
    logic [MINUTES_W-1:0] in_minutes;
    logic [SECONDS_W-1:0] in_seconds;
    stamp_t               stamp;
    win_t                 w_eff;
    logic                 accept;
    win_t                 base_fill;
    logic [PTR_W-1:0]     base_ptr;
    logic [PTR_W-1:0]     slot;
    logic                 evict;
    win_t                 fill_upd;
    logic                 out_free;

    stamp_t               ring_rd_data;
    logic                 ring_wr_en;
    logic                 div_start;
    div_status_t          div_st;
    stamp_t               div_q;

    assign in_hours   = s_tdata[HOURS_W-1:0];
    assign in_minutes = s_tdata[HOURS_W+MINUTES_W-1:HOURS_W];
    assign in_seconds = s_tdata[HOURS_W+MINUTES_W+SECONDS_W-1:HOURS_W+MINUTES_W];

    // seconds since midnight; out-of-range fields still fit in 17 bits
    assign stamp = STAMP_W'(STAMP_W'(in_hours) * HOUR_SECS
                          + STAMP_W'(in_minutes) * MIN_SECS
                          + STAMP_W'(in_seconds));

    // clamp the window length to 1..MAX_WINDOW, and to at most 127
    always_comb begin
        if (window_len_reg == '0) begin
            w_eff = WIN_W'(1);
        end else if (window_len_reg > WIN_W'(W_TOP)) begin
            w_eff = WIN_W'(W_TOP);
        end else begin
            w_eff = window_len_reg;
        end
    end

    // hold off input during a register write so no item is dropped
    assign s_tready = (state_reg == ST_IDLE) && !cfg_wr_en;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // a first-of-sequence stamp starts from an empty window
    assign base_fill = s_tuser ? '0 : fill_reg;
    assign base_ptr  = s_tuser ? '0 : ptr_reg;
    assign slot      = (CMP_W'(base_ptr) >= CMP_W'(w_eff)) ? '0 : base_ptr;
    assign evict     = (base_fill >= w_eff);
    assign fill_upd  = evict ? w_eff : WIN_W'(base_fill + 1'b1);

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        window_len_next = window_len_reg;
        sum_next        = sum_reg;
        fill_next       = fill_reg;
        ptr_next        = ptr_reg;
        v_next          = v_reg;
        slot_next       = slot_reg;
        evict_next      = evict_reg;
        emit_next       = emit_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_data_next     = m_data_reg;
        ring_wr_en      = 1'b0;
        div_start       = 1'b0;

        // drop the result once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (cfg_wr_en) begin
                    // a new window length starts a fresh sequence
                    window_len_next = cfg_wr_data;
                    sum_next        = '0;
                    fill_next       = '0;
                    ptr_next        = '0;
                end else if (accept) begin
                    // ring read of the slot goes out this cycle
                    v_next     = stamp;
                    slot_next  = slot;
                    evict_next = evict;
                    emit_next  = (fill_upd == w_eff);
                    fill_next  = fill_upd;
                    ptr_next   = (CMP_W'(slot) + CMP_W'(1) >= CMP_W'(w_eff))
                               ? '0 : PTR_W'(slot + 1'b1);
                    if (s_tuser) begin
                        sum_next = '0;
                    end
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                // retire the oldest stamp once the window is full, add the new one, write it back
                sum_next   = sum_reg - (evict_reg ? SUM_W'(ring_rd_data) : '0)
                           + SUM_W'(v_reg);
                ring_wr_en = 1'b1;
                if (emit_reg) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (div_st.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold the quotient until the output register frees up
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = div_q;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            window_len_reg <= WIN_W'(1);
            sum_reg        <= '0;
            fill_reg       <= '0;
            ptr_reg        <= '0;
            evict_reg      <= 1'b0;
            emit_reg       <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            window_len_reg <= window_len_next;
            sum_reg        <= sum_next;
            fill_reg       <= fill_next;
            ptr_reg        <= ptr_next;
            evict_reg      <= evict_next;
            emit_reg       <= emit_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        v_reg      <= v_next;
        slot_reg   <= slot_next;
        m_data_reg <= m_data_next;
    end

    // ---------------------------------------------------------------
    // Ring memory and divider
    // ---------------------------------------------------------------
    tdma_ring #(
        .DEPTH  (MAX_WINDOW),
        .ADDR_W (PTR_W)
    ) u_ring (
        .aclk    (aclk),
        .rd_en   (accept && !cfg_wr_en),
        .rd_addr (slot),
        .rd_data (ring_rd_data),
        .wr_en   (ring_wr_en),
        .wr_addr (slot_reg),
        .wr_data (v_reg)
    );

    tdma_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (w_eff),
        .status   (div_st),
        .quotient (div_q)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'(m_data_reg);

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_fill_within_window: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= w_eff)
        else $error("fill count exceeds window length");

    a_ptr_within_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (CMP_W'(ptr_reg) < CMP_W'(w_eff)))
        else $error("write pointer outside window");

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_st.busy)
        else $error("divider restarted while busy");

    a_div_done_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.done |-> (state_reg == ST_DIV))
        else $error("quotient finished outside divide state");

endmodule
`default_nettype wire
